/* hw/rtl/ordered_list_with_cursor_core_defines.svh */
// Assertion macros for the ordered list core
`ifndef ORDERED_LIST_WITH_CURSOR_CORE_DEFINES_SVH
`define ORDERED_LIST_WITH_CURSOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define OLC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("olc check failed");
`define OLC_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("olc reset check failed");
`else
`define OLC_ASSERT(label, clk, rst_n, prop)
`define OLC_ASSERT_RST(label, clk, prop)
`endif
`endif

/* hw/rtl/olc_pkg.sv */
// ----------------------------------------------------------------------------
// olc_pkg
// Types and constants for the ordered list with cursor.
// ----------------------------------------------------------------------------
package olc_pkg;
  localparam int CAPACITY = 16;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int REC_W = 32 + 64 + 64 + 32;

  typedef enum logic [3:0] {
    CMD_INS_FRONT = 4'd0, CMD_INS_REAR = 4'd1, CMD_RM_FRONT = 4'd2,
    CMD_RM_REAR = 4'd3, CMD_RM_CUR = 4'd4, CMD_FIND_NUM = 4'd5,
    CMD_FIND_NAME = 4'd6, CMD_READ_CUR = 4'd7, CMD_READ_ALL = 4'd8,
    CMD_CLEAR = 4'd9
  } cmd_t;

  localparam logic [2:0] ST_DONE = 3'd0;
  localparam logic [2:0] ST_FOUND = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_EMPTY = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_SHIFT_RD, S_SHIFT_WR, S_SCAN_RD, S_SCAN_CMP, S_READ_RD, S_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] number;
    logic [63:0] name_low;
    logic [63:0] name_mid;
    logic [31:0] name_high;
  } rec_t;

  typedef struct packed {
    logic        number_hit;
    logic        name_hit;
  } cmp_t;
endpackage

/* hw/rtl/olc_if.sv */
// ----------------------------------------------------------------------------
// olc_in_if / olc_out_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface olc_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic signed [31:0] member_number;
  logic [63:0] name_bytes_low;
  logic [63:0] name_bytes_mid;
  logic [31:0] name_bytes_high;
  modport source (output valid, command, member_number, name_bytes_low, name_bytes_mid,
                  name_bytes_high, input ready);
  modport sink (input valid, command, member_number, name_bytes_low, name_bytes_mid,
                name_bytes_high, output ready);
endinterface

interface olc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        entry_valid;
  logic signed [31:0] entry_number;
  logic [63:0] entry_name_low;
  logic [63:0] entry_name_mid;
  logic [31:0] entry_name_high;
  logic [4:0]  list_length;
  logic        last;
  modport source (output valid, status, entry_valid, entry_number, entry_name_low,
                  entry_name_mid, entry_name_high, list_length, last, input ready);
  modport sink (input valid, status, entry_valid, entry_number, entry_name_low,
                entry_name_mid, entry_name_high, list_length, last, output ready);
endinterface

/* hw/rtl/olc_ram.sv */
// ----------------------------------------------------------------------------
// olc_ram
// Generic single-port-write, single-read RAM with registered read.
// ----------------------------------------------------------------------------
module olc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/olc_cmp.sv */
// ----------------------------------------------------------------------------
// olc_cmp
// Shared record compare: number equality and NUL-terminated name match.
// ----------------------------------------------------------------------------
module olc_cmp (
  input  olc_pkg::rec_t stored,
  input  olc_pkg::rec_t key,
  output olc_pkg::cmp_t res
);
  import olc_pkg::*;

  logic [159:0] sn, kn;
  logic [19:0]  eq, nul;
  logic [19:0]  ok;
  logic         term;

  assign sn = {stored.name_high, stored.name_mid, stored.name_low};
  assign kn = {key.name_high, key.name_mid, key.name_low};

  always_comb begin
    for (int i = 0; i < 20; i++) begin
      eq[i]  = sn[i*8 +: 8] == kn[i*8 +: 8];
      nul[i] = sn[i*8 +: 8] == 8'd0;
    end
    // byte i must match unless an earlier stored byte was a matching NUL
    term = 1'b0;
    for (int i = 0; i < 20; i++) begin
      ok[i] = eq[i] | term;
      term  = term | (nul[i] & eq[i]);
    end
    res.name_hit   = &ok;
    res.number_hit = stored.number == key.number;
  end
endmodule

/* hw/rtl/ordered_list_with_cursor_core.sv */
// ----------------------------------------------------------------------------
// ordered_list_with_cursor_core
// Ordered record list with cursor, one RAM, one sequencer, one compare unit.
// ----------------------------------------------------------------------------
// channel | dir | beat
// in_     | in  | command, member_number, name bytes
// out_    | out | status, entry record, list_length, last
// Inserts and removals shift one record at a time, reading in S_SHIFT_RD and
// writing in S_SHIFT_WR. Searches read one record at a time in S_SCAN_RD and
// compare it in S_SCAN_CMP. read_all gives one beat per record, reading each
// record in S_READ_RD before its beat in S_OUT.
// Reset clears count and cursor.
// A stalled result holds; no new command is taken until its last beat.
`include "ordered_list_with_cursor_core_defines.svh"
module ordered_list_with_cursor_core (
  input logic clk,
  input logic rst_n,
  olc_in_if.sink    in_ch,
  olc_out_if.source out_ch
);
  import olc_pkg::*;

  state_t state_r, state_nxt;
  logic [3:0]       cmd_r, cmd_nxt;
  rec_t             key_r, key_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic             curv_r, curv_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;   // walk position
  logic [CNT_W-1:0] end_r, end_nxt;   // walk limit
  logic             up_r, up_nxt;     // shift direction: 1 = insert
  rec_t             hold_r, hold_nxt;
  logic [2:0]       st_r, st_nxt;
  logic             show_r, show_nxt;
  logic             last_r, last_nxt;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  rec_t             wdata, rdata;
  cmp_t             cres;
  logic             hit;
  logic             cur_ok;

  olc_ram #(.WIDTH(REC_W), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  olc_cmp u_cmp (.stored(rdata), .key(key_r), .res(cres));

  assign cur_ok = curv_r && ({1'b0, cur_r} < cnt_r);
  assign hit = (cmd_r == CMD_FIND_NUM) ? cres.number_hit : cres.name_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      cur_r   <= '0;
      curv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      cur_r   <= cur_nxt;
      curv_r  <= curv_nxt;
    end
    cmd_r  <= cmd_nxt;
    key_r  <= key_nxt;
    ptr_r  <= ptr_nxt;
    end_r  <= end_nxt;
    up_r   <= up_nxt;
    hold_r <= hold_nxt;
    st_r   <= st_nxt;
    show_r <= show_nxt;
    last_r <= last_nxt;
  end

  // next state and datapath
  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r; key_nxt = key_r; cnt_nxt = cnt_r; cur_nxt = cur_r;
    curv_nxt = curv_r; ptr_nxt = ptr_r; end_nxt = end_r; up_nxt = up_r;
    hold_nxt = hold_r; st_nxt = st_r; show_nxt = show_r; last_nxt = last_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt = in_ch.command;
          key_nxt = '{in_ch.member_number, in_ch.name_bytes_low, in_ch.name_bytes_mid,
                      in_ch.name_bytes_high};
          st_nxt = ST_DONE; show_nxt = 1'b0; last_nxt = 1'b1;
          state_nxt = S_OUT;
          case (in_ch.command)
            CMD_INS_FRONT, CMD_INS_REAR: begin
              if (cnt_r == CNT_W'(CAPACITY)) begin
                st_nxt = ST_FULL;
              end else begin
                up_nxt = 1'b1;
                ptr_nxt = cnt_r;
                end_nxt = (in_ch.command == CMD_INS_FRONT) ? '0 : cnt_r;
                cur_nxt = (in_ch.command == CMD_INS_FRONT) ? '0 : cnt_r[IDX_W-1:0];
                curv_nxt = 1'b1;
                state_nxt = S_SHIFT_RD;
              end
            end
            CMD_RM_FRONT, CMD_RM_REAR, CMD_RM_CUR: begin
              if (cnt_r == '0 || (in_ch.command == CMD_RM_CUR && !cur_ok)) begin
                st_nxt = ST_EMPTY;
              end else begin
                up_nxt = 1'b0;
                end_nxt = cnt_r - 1'b1;
                if (in_ch.command == CMD_RM_FRONT) begin
                  ptr_nxt = '0;
                end else if (in_ch.command == CMD_RM_REAR) begin
                  ptr_nxt = cnt_r - 1'b1;
                end else begin
                  ptr_nxt = {1'b0, cur_r};
                end
                if (in_ch.command == CMD_RM_REAR && cnt_r != CNT_W'(1)) begin
                  cur_nxt = IDX_W'(cnt_r - CNT_W'(2));
                  curv_nxt = 1'b1;
                end else if (in_ch.command == CMD_RM_CUR && cur_r != '0) begin
                  cur_nxt = cur_r - 1'b1;
                  curv_nxt = 1'b1;
                end else begin
                  cur_nxt = '0;
                  curv_nxt = cnt_r > CNT_W'(1);
                end
                cnt_nxt = cnt_r - 1'b1;
                state_nxt = S_SHIFT_RD;
              end
            end
            CMD_FIND_NUM, CMD_FIND_NAME: begin
              ptr_nxt = '0;
              st_nxt = ST_NOT_FOUND;
              state_nxt = (cnt_r == '0) ? S_OUT : S_SCAN_RD;
            end
            CMD_READ_CUR: begin
              if (cur_ok) begin
                ptr_nxt = {1'b0, cur_r};
                show_nxt = 1'b1;
                state_nxt = S_READ_RD;
              end else begin
                st_nxt = ST_EMPTY;
              end
            end
            CMD_READ_ALL: begin
              if (cnt_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                ptr_nxt = '0;
                show_nxt = 1'b1;
                last_nxt = cnt_r == CNT_W'(1);
                state_nxt = S_READ_RD;
              end
            end
            CMD_CLEAR: begin
              cnt_nxt = '0; cur_nxt = '0; curv_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_SHIFT_RD: begin
        if (ptr_r == end_r) begin
          if (up_r) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        ptr_nxt = up_r ? ptr_r - 1'b1 : ptr_r + 1'b1;
        state_nxt = S_SHIFT_RD;
      end
      S_SCAN_RD: state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (hit) begin
          st_nxt = ST_FOUND; show_nxt = 1'b1;
          cur_nxt = ptr_r[IDX_W-1:0]; curv_nxt = 1'b1;
          hold_nxt = rdata;
          state_nxt = S_OUT;
        end else if (ptr_r + 1'b1 == cnt_r) begin
          state_nxt = S_OUT;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_READ_RD: state_nxt = S_OUT;
      S_OUT: begin
        if (out_ch.ready) begin
          if (cmd_r == CMD_READ_ALL && !last_r) begin
            ptr_nxt = ptr_r + 1'b1;
            last_nxt = ptr_r + CNT_W'(2) == cnt_r;
            state_nxt = S_READ_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and RAM control
  always_comb begin
    we = 1'b0;
    waddr = ptr_r[IDX_W-1:0];
    wdata = rdata;
    raddr = ptr_r[IDX_W-1:0];
    case (state_r)
      S_SHIFT_RD: begin
        if (up_r) begin
          raddr = IDX_W'(ptr_r - 1'b1);
          if (ptr_r == end_r) begin
            we = 1'b1;
            wdata = key_r;
          end
        end else begin
          raddr = IDX_W'(ptr_r + 1'b1);
        end
      end
      S_SHIFT_WR: we = 1'b1;
      default: ;
    endcase
  end

  assign in_ch.ready = state_r == S_IDLE;
  assign out_ch.valid = state_r == S_OUT;
  assign out_ch.status = st_r;
  assign out_ch.entry_valid = show_r;
  assign out_ch.entry_number = show_r ? (cmd_r == CMD_FIND_NUM || cmd_r == CMD_FIND_NAME ?
                                         hold_r.number : rdata.number) : '0;
  assign out_ch.entry_name_low = show_r ? (cmd_r == CMD_FIND_NUM || cmd_r == CMD_FIND_NAME ?
                                           hold_r.name_low : rdata.name_low) : '0;
  assign out_ch.entry_name_mid = show_r ? (cmd_r == CMD_FIND_NUM || cmd_r == CMD_FIND_NAME ?
                                           hold_r.name_mid : rdata.name_mid) : '0;
  assign out_ch.entry_name_high = show_r ? (cmd_r == CMD_FIND_NUM || cmd_r == CMD_FIND_NAME ?
                                            hold_r.name_high : rdata.name_high) : '0;
  assign out_ch.list_length = 5'(cnt_r);
  assign out_ch.last = last_r;

  `OLC_ASSERT(a_count_max, clk, rst_n, cnt_r <= CNT_W'(CAPACITY))
  `OLC_ASSERT(a_no_overlap, clk, rst_n, !(in_ch.ready && out_ch.valid))
  `OLC_ASSERT(a_cursor_in_range, clk, rst_n,
              (state_r == S_IDLE && curv_r) |-> ({1'b0, cur_r} < cnt_r))
  `OLC_ASSERT_RST(a_reset_empty, clk, (rst_n && !$past(rst_n)) |-> (cnt_r == '0 && !curv_r))
endmodule
